/* sv/vau_pkg.sv */
// Shared widths, constants, arctangent steps and stage types of the vector angle unit.
`default_nettype none
package vau_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int ANGLE_FRAC_DEF  = 13;

  // scaled vector components: magnitude below 2^17, plus sign
  localparam int VEC_BITS        = 17;
  localparam int SV_W            = VEC_BITS + 1;
  localparam int PROD_W          = 2 * SV_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int MAG_W           = DOT_W - 1;
  // normalised magnitudes stay below 2^30
  localparam int NORM_BITS       = 30;
  localparam int NORM_SMAX       = MAG_W - NORM_BITS;
  localparam int SQ_W            = 2 * NORM_BITS;
  localparam int QW              = 64;
  localparam int SQRT_STEPS      = 31;
  localparam int ROOT_W          = 32;
  localparam int CORDIC_STEPS    = 30;
  localparam int ACC_FRAC        = 30;
  localparam int CX_W            = 34;
  localparam int Z_W             = 34;
  localparam int ATAN_TAB        = 10;
  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;

  // atan(2^-i) in Q30; beyond the table it equals 2^(30-i) at this precision
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525158;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = Z_W'(64'sd1 <<< (ACC_FRAC - i));
    endcase
    return v;
  endfunction

  // beat travelling through the square root cells
  typedef struct packed {
    logic                 zl;
    logic                 neg;
    logic [NORM_BITS-1:0] x;
    logic [QW-1:0]        q;
    logic [QW-1:0]        r;
  } vau_sq_t;

  // beat travelling through the rotation cells
  typedef struct packed {
    logic                  zl;
    logic                  neg;
    logic                  skip;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vau_cr_t;

endpackage
`default_nettype wire

/* sv/vau_ifs.sv */
// Handshake interfaces for the input and result channels.
`default_nettype none
interface vau_in_if #(parameter int COORD_BITS = vau_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  modport source (output valid, func, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  input ready);
  modport sink (input valid, func, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                output ready);
endinterface

interface vau_out_if #(parameter int ANGLE_W = vau_pkg::ANGLE_FRAC_DEF + 2);
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic               zero_length;
  modport source (output valid, angle, zero_length, input ready);
  modport sink (input valid, angle, zero_length, output ready);
endinterface
`default_nettype wire

/* sv/vau_front.sv */
// Front end: vector forming, scaling, dot and cross products, normalisation, squares.
`default_nettype none
module vau_front #(
  parameter int COORD_BITS = vau_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic                         func,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] az,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by_coord,
  input  wire logic signed [COORD_BITS-1:0] bz,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  input  wire logic signed [COORD_BITS-1:0] cz,
  output logic                              vld_o,
  output vau_pkg::vau_sq_t                  sq_o
);
  import vau_pkg::*;

  localparam int CW   = COORD_BITS + 1;
  localparam int MGW  = (CW > VEC_BITS) ? CW : VEC_BITS;
  localparam int SMAX = (CW > VEC_BITS) ? CW - VEC_BITS : 0;

  function automatic logic signed [CW-1:0] ext(input logic signed [COORD_BITS-1:0] c);
    return CW'(c);
  endfunction

  function automatic logic [MGW-1:0] mag_of(input logic signed [CW-1:0] c);
    logic [CW-1:0] t;
    t = c[CW-1] ? CW'(-c) : CW'(c);
    return MGW'(t);
  endfunction

  // shift a vector down until its largest magnitude is below 2^17
  function automatic void scale3(input logic signed [CW-1:0] c0, c1, c2,
                                 output logic signed [SV_W-1:0] s0, s1, s2);
    logic [MGW-1:0] m0, m1, m2, mx;
    int             sh;
    m0 = mag_of(c0);
    m1 = mag_of(c1);
    m2 = mag_of(c2);
    mx = (m0 > m1) ? m0 : m1;
    mx = (mx > m2) ? mx : m2;
    sh = SMAX;
    for (int k = SMAX; k >= 0; k--) begin
      if ((mx >> k) < (MGW+1)'(64'd1 << VEC_BITS)) sh = k;
    end
    m0 = m0 >> sh;
    m1 = m1 >> sh;
    m2 = m2 >> sh;
    s0 = c0[CW-1] ? -SV_W'(m0[VEC_BITS-1:0]) : SV_W'(m0[VEC_BITS-1:0]);
    s1 = c1[CW-1] ? -SV_W'(m1[VEC_BITS-1:0]) : SV_W'(m1[VEC_BITS-1:0]);
    s2 = c2[CW-1] ? -SV_W'(m2[VEC_BITS-1:0]) : SV_W'(m2[VEC_BITS-1:0]);
  endfunction

  function automatic logic [MAG_W-1:0] mag_d(input logic signed [DOT_W-1:0] c);
    logic [DOT_W-1:0] t;
    t = c[DOT_W-1] ? DOT_W'(-c) : DOT_W'(c);
    return t[MAG_W-1:0];
  endfunction

  logic [6:0] vld_r;

  // stage 1: form u and v
  logic signed [CW-1:0] u_r [3];
  logic signed [CW-1:0] v_r [3];
  logic signed [CW-1:0] u_nxt [3];
  logic signed [CW-1:0] v_nxt [3];
  logic [6:0] zl_r;
  logic       zl1_nxt;

  always_comb begin
    if (func) begin
      u_nxt[0] = ext(bx) - ext(ax);
      u_nxt[1] = ext(by_coord) - ext(ay);
      u_nxt[2] = ext(bz) - ext(az);
      v_nxt[0] = ext(cx) - ext(bx);
      v_nxt[1] = ext(cy) - ext(by_coord);
      v_nxt[2] = ext(cz) - ext(bz);
    end else begin
      u_nxt[0] = ext(ax);
      u_nxt[1] = ext(ay);
      u_nxt[2] = ext(az);
      v_nxt[0] = ext(bx);
      v_nxt[1] = ext(by_coord);
      v_nxt[2] = ext(bz);
    end
    zl1_nxt = (u_nxt[0] == '0 && u_nxt[1] == '0 && u_nxt[2] == '0) ||
              (v_nxt[0] == '0 && v_nxt[1] == '0 && v_nxt[2] == '0);
  end

  // stage 2: scale both vectors
  logic signed [SV_W-1:0] us_r [3];
  logic signed [SV_W-1:0] vs_r [3];
  logic signed [SV_W-1:0] us_nxt [3];
  logic signed [SV_W-1:0] vs_nxt [3];

  always_comb begin
    scale3(u_r[0], u_r[1], u_r[2], us_nxt[0], us_nxt[1], us_nxt[2]);
    scale3(v_r[0], v_r[1], v_r[2], vs_nxt[0], vs_nxt[1], vs_nxt[2]);
  end

  // stage 3: the nine products
  logic signed [PROD_W-1:0] p_r [9];
  logic signed [PROD_W-1:0] p_nxt [9];

  always_comb begin
    p_nxt[0] = us_r[0] * vs_r[0];
    p_nxt[1] = us_r[1] * vs_r[1];
    p_nxt[2] = us_r[2] * vs_r[2];
    p_nxt[3] = us_r[1] * vs_r[2];
    p_nxt[4] = us_r[2] * vs_r[1];
    p_nxt[5] = us_r[2] * vs_r[0];
    p_nxt[6] = us_r[0] * vs_r[2];
    p_nxt[7] = us_r[0] * vs_r[1];
    p_nxt[8] = us_r[1] * vs_r[0];
  end

  // stage 4: dot and cross sums
  logic signed [DOT_W-1:0] d_r, d_nxt;
  logic signed [DOT_W-1:0] w_r [3];
  logic signed [DOT_W-1:0] w_nxt [3];

  always_comb begin
    d_nxt    = DOT_W'(p_r[0]) + DOT_W'(p_r[1]) + DOT_W'(p_r[2]);
    w_nxt[0] = DOT_W'(p_r[3]) - DOT_W'(p_r[4]);
    w_nxt[1] = DOT_W'(p_r[5]) - DOT_W'(p_r[6]);
    w_nxt[2] = DOT_W'(p_r[7]) - DOT_W'(p_r[8]);
  end

  // stage 5: magnitudes shifted so the largest is below 2^30
  logic                 neg_r [3];
  logic                 neg_nxt;
  logic [NORM_BITS-1:0] xn_r, xn_nxt;
  logic [NORM_BITS-1:0] wn_r [3];
  logic [NORM_BITS-1:0] wn_nxt [3];

  always_comb begin
    logic [MAG_W-1:0] dm, m0, m1, m2, mx;
    int               sh;
    dm = mag_d(d_r);
    m0 = mag_d(w_r[0]);
    m1 = mag_d(w_r[1]);
    m2 = mag_d(w_r[2]);
    mx = (dm > m0) ? dm : m0;
    mx = (mx > m1) ? mx : m1;
    mx = (mx > m2) ? mx : m2;
    sh = NORM_SMAX;
    for (int k = NORM_SMAX; k >= 0; k--) begin
      if ((mx >> k) < MAG_W'(64'd1 << NORM_BITS)) sh = k;
    end
    dm = dm >> sh;
    m0 = m0 >> sh;
    m1 = m1 >> sh;
    m2 = m2 >> sh;
    xn_nxt    = dm[NORM_BITS-1:0];
    wn_nxt[0] = m0[NORM_BITS-1:0];
    wn_nxt[1] = m1[NORM_BITS-1:0];
    wn_nxt[2] = m2[NORM_BITS-1:0];
    neg_nxt   = d_r[DOT_W-1];
  end

  // stage 6: squares of the cross components
  logic [SQ_W-1:0]      sq_r [3];
  logic [SQ_W-1:0]      sq_nxt [3];
  logic [NORM_BITS-1:0] x6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_nxt[i] = wn_r[i] * wn_r[i];
  end

  // stage 7: sum of squares
  logic [QW-1:0]        q_r, q_nxt;
  logic [NORM_BITS-1:0] x7_r;

  assign q_nxt = QW'(sq_r[0]) + QW'(sq_r[1]) + QW'(sq_r[2]);

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      zl_r     <= {zl_r[5:0], zl1_nxt};
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      us_r     <= us_nxt;
      vs_r     <= vs_nxt;
      p_r      <= p_nxt;
      d_r      <= d_nxt;
      w_r      <= w_nxt;
      neg_r[0] <= neg_nxt;
      neg_r[1] <= neg_r[0];
      neg_r[2] <= neg_r[1];
      xn_r     <= xn_nxt;
      wn_r     <= wn_nxt;
      sq_r     <= sq_nxt;
      x6_r     <= xn_r;
      q_r      <= q_nxt;
      x7_r     <= x6_r;
    end
  end

  assign vld_o   = vld_r[6];
  assign sq_o.zl  = zl_r[6];
  assign sq_o.neg = neg_r[2];
  assign sq_o.x   = x7_r;
  assign sq_o.q   = q_r;
  assign sq_o.r   = '0;

endmodule
`default_nettype wire

/* sv/vau_sqrt_cell.sv */
// One bit step of the integer square root chain.
`default_nettype none
module vau_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire vau_pkg::vau_sq_t d_i,
  output logic                  vld_o,
  output vau_pkg::vau_sq_t      d_o
);
  import vau_pkg::*;

  localparam logic [QW-1:0] BIT = QW'(64'd1 << (2 * (SQRT_STEPS - 1 - STEP)));

  logic             vld_r;
  vau_sq_t          d_r, d_nxt;
  logic [QW-1:0]    trial;

  // try the next root bit against the remainder
  always_comb begin
    trial = d_i.r + BIT;
    d_nxt = d_i;
    if (d_i.q >= trial) begin
      d_nxt.q = d_i.q - trial;
      d_nxt.r = (d_i.r >> 1) + BIT;
    end else begin
      d_nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule
`default_nettype wire

/* sv/vau_cordic_cell.sv */
// One vectoring rotation of the arctangent chain.
`default_nettype none
module vau_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire vau_pkg::vau_cr_t d_i,
  output logic                  vld_o,
  output vau_pkg::vau_cr_t      d_o
);
  import vau_pkg::*;

  localparam logic signed [Z_W-1:0] AT = atan_step(STEP);

  logic                   vld_r;
  vau_cr_t                d_r, d_nxt;
  logic signed [CX_W-1:0] dx, dy;

  // rotate towards y = 0, steering on the sign of y
  always_comb begin
    dx    = d_i.y >>> STEP;
    dy    = d_i.x >>> STEP;
    d_nxt = d_i;
    if (d_i.y > 0) begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + AT;
    end else begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - AT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule
`default_nettype wire

/* sv/vector_angle_unit.sv */
// Top level of the vector angle unit: front end, root and rotation chains, output buffer.
//
// The unit takes one beat per cycle unless stalled and returns the angle between
// two 3D vectors (a and b, or b-a and c-b when func is set) through 7 front-end stages
// (vector forming, scaling, products, sums, normalisation, squares, sum of squares),
// 31 square-root cells, 30 rotation cells and the output register. The whole path is
// one flow-controlled pipeline, so the rate is one beat per clock while the result
// side keeps taking beats; a skid register behind the output lets a new beat enter
// in the cycle a finished result stalls. A zero-length vector gives angle 0 with
// zero_length set. There is no state between beats and nothing to configure.
`default_nettype none
module vector_angle_unit #(
  parameter int COORD_BITS      = vau_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = vau_pkg::ANGLE_FRAC_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vau_in_if.sink    in_bus,
  vau_out_if.source out_bus
);
  import vau_pkg::*;

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 2;
  localparam int SH      = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W:0] HALF = (Z_W+1)'(64'd1 << (SH - 1));

  logic pipe_en;

  // front end
  logic    sq_v [SQRT_STEPS+1];
  vau_sq_t sq_d [SQRT_STEPS+1];

  vau_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .vld_i    (in_bus.valid),
    .func     (in_bus.func),
    .ax       (in_bus.ax),
    .ay       (in_bus.ay),
    .az       (in_bus.az),
    .bx       (in_bus.bx),
    .by_coord (in_bus.by_coord),
    .bz       (in_bus.bz),
    .cx       (in_bus.cx),
    .cy       (in_bus.cy),
    .cz       (in_bus.cz),
    .vld_o    (sq_v[0]),
    .sq_o     (sq_d[0])
  );

  // square root chain
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    vau_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .vld_i (sq_v[k]),
      .d_i   (sq_d[k]),
      .vld_o (sq_v[k+1]),
      .d_o   (sq_d[k+1])
    );
  end

  // hand-over: x from the dot product, y the root
  logic    cr_v [CORDIC_STEPS+1];
  vau_cr_t cr_d [CORDIC_STEPS+1];

  always_comb begin
    cr_v[0]      = sq_v[SQRT_STEPS];
    cr_d[0].zl   = sq_d[SQRT_STEPS].zl;
    cr_d[0].neg  = sq_d[SQRT_STEPS].neg;
    cr_d[0].skip = (sq_d[SQRT_STEPS].r == '0);
    cr_d[0].x    = CX_W'(sq_d[SQRT_STEPS].x);
    cr_d[0].y    = CX_W'(sq_d[SQRT_STEPS].r[ROOT_W-1:0]);
    cr_d[0].z    = '0;
  end

  // rotation chain
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    vau_cordic_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .vld_i (cr_v[k]),
      .d_i   (cr_d[k]),
      .vld_o (cr_v[k+1]),
      .d_o   (cr_d[k+1])
    );
  end

  // fold by the sign of the dot product, clamp and round half up
  logic               fin_vld;
  logic [ANGLE_W-1:0] fin_angle;
  logic               fin_zl;

  always_comb begin
    logic signed [Z_W-1:0] z;
    logic signed [Z_W:0]   th;
    logic signed [Z_W:0]   rnd;
    z  = cr_d[CORDIC_STEPS].skip ? '0 : cr_d[CORDIC_STEPS].z;
    th = cr_d[CORDIC_STEPS].neg ? ((Z_W+1)'(PI_Q30) - (Z_W+1)'(z)) : (Z_W+1)'(z);
    if (th < 0) th = '0;
    if (th > (Z_W+1)'(PI_Q30)) th = (Z_W+1)'(PI_Q30);
    rnd       = (th + HALF) >>> SH;
    fin_vld   = cr_v[CORDIC_STEPS];
    fin_zl    = cr_d[CORDIC_STEPS].zl;
    fin_angle = fin_zl ? '0 : rnd[ANGLE_W-1:0];
  end

  // output register with skid stage
  logic               out_vld_r, out_vld_nxt;
  logic [ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic               out_zl_r, out_zl_nxt;
  logic               skid_vld_r, skid_vld_nxt;
  logic [ANGLE_W-1:0] skid_angle_r, skid_angle_nxt;
  logic               skid_zl_r, skid_zl_nxt;

  assign pipe_en = !skid_vld_r;

  always_comb begin
    out_vld_nxt    = out_vld_r;
    out_angle_nxt  = out_angle_r;
    out_zl_nxt     = out_zl_r;
    skid_vld_nxt   = skid_vld_r;
    skid_angle_nxt = skid_angle_r;
    skid_zl_nxt    = skid_zl_r;
    if (skid_vld_r) begin
      if (out_bus.ready) begin
        out_angle_nxt = skid_angle_r;
        out_zl_nxt    = skid_zl_r;
        skid_vld_nxt  = 1'b0;
      end
    end else if (!out_vld_r || out_bus.ready) begin
      out_vld_nxt   = fin_vld;
      out_angle_nxt = fin_angle;
      out_zl_nxt    = fin_zl;
    end else if (fin_vld) begin
      skid_vld_nxt   = 1'b1;
      skid_angle_nxt = fin_angle;
      skid_zl_nxt    = fin_zl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r  <= out_angle_nxt;
    out_zl_r     <= out_zl_nxt;
    skid_angle_r <= skid_angle_nxt;
    skid_zl_r    <= skid_zl_nxt;
  end

  assign in_bus.ready        = pipe_en;
  assign out_bus.valid       = out_vld_r;
  assign out_bus.angle       = out_angle_r;
  assign out_bus.zero_length = out_zl_r;

endmodule
`default_nettype wire

/* sv/vau_checker.sv */
// Port-level checks of the vector angle unit and their binding to the top level.
`default_nettype none
module vau_checker #(
  parameter int ANGLE_FRAC_BITS = vau_pkg::ANGLE_FRAC_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ANGLE_FRAC_BITS+1:0] out_angle,
  input wire logic                       out_zero_length
);
  import vau_pkg::*;

  localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ANGLE_FRAC_BITS+1:0] PI_ROUND =
    (ANGLE_FRAC_BITS+2)'((64'd3373259426 + (64'd1 << (SH - 1))) >> SH);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // zero-length vectors report angle zero
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_angle == '0)
    else $error("zero-length beat with nonzero angle");

  // the angle never exceeds pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle <= PI_ROUND)
    else $error("angle above pi");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector_angle_unit vau_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_vau_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_angle       (out_bus.angle),
  .out_zero_length (out_bus.zero_length)
);
`default_nettype wire

/* verif/tb.sv */
// Testbench for the vector angle unit: random and directed beats, scoreboard against a local model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vau_pkg::*;

  typedef struct {
    logic        func;
    logic [15:0] c [9];
  } beat_t;

  typedef struct {
    logic [14:0] angle;
    logic        zl;
  } res_t;

  // Angle prediction, fixed point as the hardware does it
  function automatic res_t predict_angle(beat_t b);
    longint a[3], bb[3], cc[3], u[3], v[3], w[3];
    longint d, x, y, z, th, dx, dy, at;
    longint unsigned wm[3], dm, m, q, r, bit_v, t;
    int s;
    res_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(b.c[i]));
      bb[i] = longint'($signed(b.c[3+i]));
      cc[i] = longint'($signed(b.c[6+i]));
      u[i] = b.func ? bb[i] - a[i] : a[i];
      v[i] = b.func ? cc[i] - bb[i] : bb[i];
    end
    if ((u[0] == 0 && u[1] == 0 && u[2] == 0) || (v[0] == 0 && v[1] == 0 && v[2] == 0)) begin
      res.angle = '0;
      res.zl = 1'b1;
      return res;
    end
    // components stay below 2^17 at 16-bit width, so no vector scaling
    d = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    w[0] = u[1]*v[2] - u[2]*v[1];
    w[1] = u[2]*v[0] - u[0]*v[2];
    w[2] = u[0]*v[1] - u[1]*v[0];
    dm = d < 0 ? -d : d;
    m = dm;
    for (int i = 0; i < 3; i++) begin
      wm[i] = w[i] < 0 ? -w[i] : w[i];
      if (wm[i] > m) m = wm[i];
    end
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      t = wm[i] >> s;
      q += t * t;
    end
    // integer square root
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > q) bit_v >>= 2;
    while (bit_v != 0) begin
      if (q >= r + bit_v) begin
        q -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    y = r;
    x = dm >> s;
    z = 0;
    if (y != 0) begin
      for (int i = 0; i < 30; i++) begin
        at = i < ATAN_TAB ? longint'(atan_step(i)) : (longint'(1) <<< (30 - i));
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += at;
        end else begin
          x -= dx; y += dy; z -= at;
        end
      end
    end
    th = d < 0 ? 64'sd3373259426 - z : z;
    if (th < 0) th = 0;
    if (th > 64'sd3373259426) th = 64'sd3373259426;
    th = (th + (longint'(1) <<< 16)) >>> 17;
    res.angle = th[14:0];
    res.zl = 1'b0;
    return res;
  endfunction

  // Scoreboard: queue of predicted angles
  class angle_board;
    res_t pending[$];
    int errors = 0;
    function void note_beat(beat_t b);
      pending.push_back(predict_angle(b));
    endfunction
    function void check_result(logic [14:0] angle, logic zl);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result angle=%0d zl=%0d", angle, zl);
        return;
      end
      e = pending.pop_front();
      if (e.angle !== angle || e.zl !== zl) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp angle=%0d zl=%0d got angle=%0d zl=%0d",
                   e.angle, e.zl, angle, zl);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  vau_in_if  in_bus();
  vau_out_if out_bus();

  vector_angle_unit u_dut (.clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus));

  angle_board sb = new();
  bit quiet = 0;       // no idling in the final part
  bit long_hold = 0;   // sink holds off for a long stretch
  bit stim_done = 0;
  int idle_cycles = 0;

  initial forever #5 clk = ~clk;

  initial begin
    in_bus.valid = 0;
    in_bus.func = 0;
    in_bus.ax = 0; in_bus.ay = 0; in_bus.az = 0;
    in_bus.bx = 0; in_bus.by_coord = 0; in_bus.bz = 0;
    in_bus.cx = 0; in_bus.cy = 0; in_bus.cz = 0;
    out_bus.ready = 0;
  end

  // Accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      beat_t b;
      b.func = in_bus.func;
      b.c[0] = in_bus.ax; b.c[1] = in_bus.ay; b.c[2] = in_bus.az;
      b.c[3] = in_bus.bx; b.c[4] = in_bus.by_coord; b.c[5] = in_bus.bz;
      b.c[6] = in_bus.cx; b.c[7] = in_bus.cy; b.c[8] = in_bus.cz;
      sb.note_beat(b);
    end
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.angle, out_bus.zero_length);
  end

  // Watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_bus.ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        out_bus.ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_bus.ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(beat_t b);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      in_bus.valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.func <= b.func;
    in_bus.ax <= b.c[0]; in_bus.ay <= b.c[1]; in_bus.az <= b.c[2];
    in_bus.bx <= b.c[3]; in_bus.by_coord <= b.c[4]; in_bus.bz <= b.c[5];
    in_bus.cx <= b.c[6]; in_bus.cy <= b.c[7]; in_bus.cz <= b.c[8];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    b.func = 1'($urandom_range(0, 1));
    for (int i = 0; i < 9; i++) b.c[i] = rand_coord();
    // parallel or zero-length cases now and then
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) b.c[3+i] = b.c[i];
      1: for (int i = 0; i < 3; i++) b.c[3+i] = -b.c[i];
      2: for (int i = 0; i < 3; i++) b.c[i] = '0;
      3: for (int i = 0; i < 3; i++) b.c[6+i] = b.c[3+i];
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    beat_t b;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: extremes, both modes, zero length, parallel and opposite
    for (int k = 0; k < 20; k++) begin
      b.func = k[0];
      for (int i = 0; i < 9; i++) b.c[i] = '0;
      case (k >> 1)
        0: ;
        1: for (int i = 0; i < 9; i++) b.c[i] = 16'h7fff;
        2: for (int i = 0; i < 9; i++) b.c[i] = 16'h8000;
        3: for (int i = 0; i < 9; i++) b.c[i] = i[0] ? 16'h8000 : 16'h7fff;
        4: begin b.c[0] = 16'h0100; b.c[4] = 16'h0100; b.c[8] = 16'h0100; end
        5: begin b.c[0] = 16'h0100; b.c[3] = 16'hff00; b.c[6] = 16'h0100; end
        6: begin b.c[0] = 16'h0001; b.c[3] = 16'h0001; b.c[6] = 16'h0001; end
        7: begin b.c[0] = 16'h8000; b.c[3] = 16'h7fff; b.c[7] = 16'h8000; end
        8: begin b.c[0] = 16'hffff; b.c[4] = 16'h0001; b.c[6] = 16'h7fff; end
        default: begin b.c[2] = 16'h0003; b.c[5] = 16'h0006; b.c[8] = 16'h8000; end
      endcase
      send_beat(b);
    end
    // Random body; one long sink hold-off and one drain pause along the way
    for (int k = 0; k < 600; k++) begin
      if (k == 150) long_hold = 1;
      if (k == 300) begin
        in_bus.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if (k == 500) quiet = 1;
      send_beat(rand_beat());
    end
    in_bus.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
